/* src/asc_pkg.sv */
// Shared types, constants and helper functions of the Ascon-128 AEAD engine.
// No dependencies; imported by every other file of the block.
package asc_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned NB_W = 4;
	localparam int unsigned RND_W = 4;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [4:0] sponge_t;
	typedef logic [NB_W-1:0] nbytes_t;
	typedef logic [RND_W-1:0] rnd_t;

	localparam word_t IV_128 = 64'h80400c0600000000;
	localparam word_t PAD_TOP = 64'h8000000000000000;
	localparam nbytes_t FULL_BYTES = 4'd8;
	localparam rnd_t RND_FIRST_12 = 4'd0;
	localparam rnd_t RND_FIRST_6 = 4'd6;
	localparam rnd_t RND_LAST = 4'd11;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_AD    = 2'd1,
		ACT_TEXT  = 2'd2,
		ACT_FINAL = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_INIT = 2'd1,
		PH_AD   = 2'd2,
		PH_TEXT = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		REG_KEY_HIGH = 2'd0,
		REG_KEY_LOW  = 2'd1,
		REG_DECRYPT  = 2'd2,
		REG_NONE     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		word_t key_high;
		word_t key_low;
		logic  decrypt;
	} cfg_t;

	function automatic word_t rotr(word_t x, int unsigned n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic word_t round_const(rnd_t r);
		return {56'd0, 4'(4'hF - r), r};
	endfunction

	// top n bytes set, n in 0..8
	function automatic word_t top_mask(nbytes_t n);
		return ~({WORD_W{1'b1}} >> {n, 3'b000});
	endfunction

	// padding bit after the top n bytes, zero for a full block
	function automatic word_t pad_bit(nbytes_t n);
		return PAD_TOP >> {n, 3'b000};
	endfunction

endpackage

/* src/asc_round.sv */
// One round of the Ascon permutation: constant addition, S-box layer, linear layer.
// Depends on asc_pkg.
module asc_round
	import asc_pkg::*;
(
	input  sponge_t s,
	input  rnd_t    rnd,
	output sponge_t result
);

	sponge_t x;
	sponge_t t;

	always_comb begin
		x = s;
		x[2] = x[2] ^ round_const(rnd);
		x[0] = x[0] ^ x[4];
		x[4] = x[4] ^ x[3];
		x[2] = x[2] ^ x[1];
		t[0] = x[0] ^ (~x[1] & x[2]);
		t[1] = x[1] ^ (~x[2] & x[3]);
		t[2] = x[2] ^ (~x[3] & x[4]);
		t[3] = x[3] ^ (~x[4] & x[0]);
		t[4] = x[4] ^ (~x[0] & x[1]);
		t[1] = t[1] ^ t[0];
		t[0] = t[0] ^ t[4];
		t[3] = t[3] ^ t[2];
		t[2] = ~t[2];
		result[0] = t[0] ^ rotr(t[0], 19) ^ rotr(t[0], 28);
		result[1] = t[1] ^ rotr(t[1], 61) ^ rotr(t[1], 39);
		result[2] = t[2] ^ rotr(t[2], 1) ^ rotr(t[2], 6);
		result[3] = t[3] ^ rotr(t[3], 10) ^ rotr(t[3], 17);
		result[4] = t[4] ^ rotr(t[4], 7) ^ rotr(t[4], 41);
	end

endmodule

/* src/asc_cfg.sv */
// APB register bank: key halves and decrypt mode, 64-bit registers at 8-byte steps.
// Depends on asc_pkg.
module asc_cfg
	import asc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  word_t             pwdata,
	output word_t             prdata,
	output cfg_t              cfg
);

	reg_idx_t idx;
	logic     wr_en;
	cfg_t     cfg_q;

	assign idx = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_KEY_HIGH: cfg_q.key_high <= pwdata;
				REG_KEY_LOW:  cfg_q.key_low <= pwdata;
				REG_DECRYPT:  cfg_q.decrypt <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KEY_HIGH: prdata = cfg_q.key_high;
			REG_KEY_LOW:  prdata = cfg_q.key_low;
			REG_DECRYPT:  prdata = {{(WORD_W-1){1'b0}}, cfg_q.decrypt};
			default:      prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* src/ascon128_aead_engine.sv */
// Ascon-128 AEAD engine top level: sequencer, sponge state, output register.
// Depends on asc_pkg, asc_round and asc_cfg.
//
// One item is taken at a time; in_stall stays high until the item is done. A single
// round unit runs one permutation round per cycle. Full and short last associated-data
// blocks pass decode, 6 rounds and update; a full text block decode, 6 rounds, update
// and result; a short last text block decode and result; a start item decode, all rounds
// and update; a finalize decode, all rounds, update and result. A dropped item or an
// empty associated data passes decode only. Closing a pending associated-data padding
// adds decode, 6 rounds and update to the first text or finalize item, and closing an
// empty associated data adds a decode. The result step lasts until the output register
// is free. A result waits in the output register while the next item is taken.
module ascon128_aead_engine
	import asc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	input  word_t             data_word,
	input  word_t             second_word,
	input  nbytes_t           valid_bytes,
	output logic              out_valid,
	input  logic              out_stall,
	output word_t             out_word,
	output word_t             tag_high,
	output word_t             tag_low,
	output logic              tag_match,
	output logic              is_tag,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  word_t             pwdata,
	output word_t             prdata,
	output logic              pready
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_PERM   = 5'b00100,
		ST_POST   = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		POST_START  = 3'd0,
		POST_NONE   = 3'd1,
		POST_DOMSEP = 3'd2,
		POST_REDO   = 3'd3,
		POST_TEXT   = 3'd4,
		POST_FINAL  = 3'd5
	} post_t;

	cfg_t    cfg;
	state_t  st_q, st_d;
	post_t   post_q, post_d;
	phase_t  phase_q, phase_d;
	logic    closed_q, closed_d;
	rnd_t    rnd_q, rnd_d;
	sponge_t s_q, s_d;
	sponge_t round_s;
	word_t   res_q, res_d;

	action_t act_q;
	word_t   data_q;
	word_t   second_q;
	nbytes_t nb_q;

	logic    in_acc;
	logic    out_free;
	word_t   mask;
	word_t   pad;
	word_t   ct;
	word_t   text_w;
	word_t   text_res;

	logic    out_valid_q;
	word_t   out_word_q;
	word_t   tag_high_q;
	word_t   tag_low_q;
	logic    tag_match_q;
	logic    is_tag_q;

	asc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	asc_round u_round (
		.s      (s_q),
		.rnd    (rnd_q),
		.result (round_s)
	);

	assign pready = 1'b1;
	assign in_stall = (st_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign mask = top_mask(nb_q);
	assign pad = pad_bit(nb_q);
	assign ct = data_q & mask;
	assign text_w = cfg.decrypt ? ((s_q[0] & ~mask) | ct) : (s_q[0] ^ ct);
	assign text_res = cfg.decrypt ? ((s_q[0] ^ ct) & mask) : ((s_q[0] ^ ct) & mask);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q <= action_t'(action);
			data_q <= data_word;
			second_q <= second_word;
			nb_q <= (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
		end
	end

	always_comb begin
		st_d = st_q;
		post_d = post_q;
		phase_d = phase_q;
		closed_d = closed_q;
		rnd_d = rnd_q;
		s_d = s_q;
		res_d = res_q;
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc) st_d = ST_DECODE;
			end
			ST_DECODE: begin
				priority if (act_q == ACT_START) begin
					s_d[0] = IV_128;
					s_d[1] = cfg.key_high;
					s_d[2] = cfg.key_low;
					s_d[3] = data_q;
					s_d[4] = second_q;
					rnd_d = RND_FIRST_12;
					post_d = POST_START;
					st_d = ST_PERM;
				end else if (phase_q == PH_IDLE) begin
					st_d = ST_IDLE;
				end else if (act_q == ACT_AD) begin
					priority if (phase_q == PH_TEXT) begin
						st_d = ST_IDLE;
					end else if (nb_q == FULL_BYTES) begin
						s_d[0] = s_q[0] ^ data_q;
						phase_d = PH_AD;
						rnd_d = RND_FIRST_6;
						post_d = POST_NONE;
						st_d = ST_PERM;
					end else if (nb_q == '0 && phase_q == PH_INIT) begin
						s_d[4] = s_q[4] ^ 64'd1;
						phase_d = PH_TEXT;
						closed_d = 1'b0;
						st_d = ST_IDLE;
					end else begin
						s_d[0] = s_q[0] ^ ct ^ pad;
						rnd_d = RND_FIRST_6;
						post_d = POST_DOMSEP;
						st_d = ST_PERM;
					end
				end else if (phase_q == PH_AD) begin
					s_d[0] = s_q[0] ^ PAD_TOP;
					rnd_d = RND_FIRST_6;
					post_d = POST_REDO;
					st_d = ST_PERM;
				end else if (phase_q == PH_INIT) begin
					s_d[4] = s_q[4] ^ 64'd1;
					phase_d = PH_TEXT;
					closed_d = 1'b0;
				end else if (act_q == ACT_TEXT) begin
					if (closed_q) begin
						st_d = ST_IDLE;
					end else begin
						res_d = text_res;
						post_d = POST_TEXT;
						if (nb_q == FULL_BYTES) begin
							s_d[0] = text_w;
							rnd_d = RND_FIRST_6;
							st_d = ST_PERM;
						end else begin
							s_d[0] = text_w ^ pad;
							closed_d = 1'b1;
							st_d = ST_EMIT;
						end
					end
				end else begin
					s_d[0] = closed_q ? s_q[0] : (s_q[0] ^ PAD_TOP);
					s_d[1] = s_q[1] ^ cfg.key_high;
					s_d[2] = s_q[2] ^ cfg.key_low;
					rnd_d = RND_FIRST_12;
					post_d = POST_FINAL;
					st_d = ST_PERM;
				end
			end
			ST_PERM: begin
				s_d = round_s;
				rnd_d = rnd_q + 4'd1;
				if (rnd_q == RND_LAST) st_d = ST_POST;
			end
			ST_POST: begin
				unique case (post_q)
					POST_START: begin
						s_d[3] = s_q[3] ^ cfg.key_high;
						s_d[4] = s_q[4] ^ cfg.key_low;
						phase_d = PH_INIT;
						closed_d = 1'b0;
						st_d = ST_IDLE;
					end
					POST_NONE: st_d = ST_IDLE;
					POST_DOMSEP: begin
						s_d[4] = s_q[4] ^ 64'd1;
						phase_d = PH_TEXT;
						closed_d = 1'b0;
						st_d = ST_IDLE;
					end
					POST_REDO: begin
						s_d[4] = s_q[4] ^ 64'd1;
						phase_d = PH_TEXT;
						closed_d = 1'b0;
						st_d = ST_DECODE;
					end
					POST_TEXT: st_d = ST_EMIT;
					POST_FINAL: begin
						s_d[3] = s_q[3] ^ cfg.key_high;
						s_d[4] = s_q[4] ^ cfg.key_low;
						phase_d = PH_IDLE;
						closed_d = 1'b0;
						st_d = ST_EMIT;
					end
					default: st_d = ST_IDLE;
				endcase
			end
			ST_EMIT: begin
				if (out_free) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			post_q <= POST_NONE;
			phase_q <= PH_IDLE;
			closed_q <= 1'b0;
			rnd_q <= '0;
			s_q <= '0;
		end else begin
			st_q <= st_d;
			post_q <= post_d;
			phase_q <= phase_d;
			closed_q <= closed_d;
			rnd_q <= rnd_d;
			s_q <= s_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_EMIT && out_free) begin
			if (post_q == POST_FINAL) begin
				out_word_q <= '0;
				tag_high_q <= s_q[3];
				tag_low_q <= s_q[4];
				tag_match_q <= cfg.decrypt && (s_q[3] == data_q) && (s_q[4] == second_q);
				is_tag_q <= 1'b1;
			end else begin
				out_word_q <= res_q;
				tag_high_q <= '0;
				tag_low_q <= '0;
				tag_match_q <= 1'b0;
				is_tag_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = out_word_q;
	assign tag_high = tag_high_q;
	assign tag_low = tag_low_q;
	assign tag_match = tag_match_q;
	assign is_tag = is_tag_q;

	a_closed_needs_text: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |-> phase_q == PH_TEXT)
		else $error("text closed outside the text phase");

	a_round_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_PERM |-> rnd_q <= RND_LAST)
		else $error("round index beyond the last round");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_EMIT && out_free |=> out_valid_q && st_q == ST_IDLE)
		else $error("result not loaded into the output register");

	a_tag_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && is_tag_q |-> out_word_q == '0)
		else $error("finalize result carries text bytes");

	a_text_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !is_tag_q |-> tag_high_q == '0 && tag_low_q == '0 && !tag_match_q)
		else $error("text result carries tag fields");

endmodule
